[src/canaf_pkg.sv]
// Shared types and constants of the CAN acceptance filter and receive FIFO.
package canaf_pkg;

  localparam int IdW      = 29;
  localparam int DlcW     = 4;
  localparam int DataW    = 64;
  localparam int BankW    = 2 * IdW;
  localparam int HdrW     = DlcW + IdW;
  localparam int NumBanks = 4;
  localparam int StatW    = 2;
  localparam int OvfW     = 32;
  localparam int CfgIdxW  = 3;
  localparam int MaxDlc   = 8;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE = 3'd0,
    CFG_BANK0  = 3'd1,
    CFG_BANK1  = 3'd2,
    CFG_BANK2  = 3'd3,
    CFG_BANK3  = 3'd4
  } cfg_idx_e;

  typedef logic [NumBanks-1:0] active_t;

  typedef struct packed {
    logic [IdW-1:0] mask;
    logic [IdW-1:0] ident;
  } bank_t;

  typedef struct packed {
    logic any_on;
    logic hit;
  } filt_res_t;

endpackage

[src/canaf_if.sv]
// Request and result channel interfaces of the CAN receive FIFO.
interface canaf_req_if;
  import canaf_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [IdW-1:0]    frame_id;
  logic [DlcW-1:0]   frame_dlc;
  logic [DataW-1:0]  frame_data;

  modport source (output valid, mode, frame_id, frame_dlc, frame_data, input ready);
  modport sink   (input valid, mode, frame_id, frame_dlc, frame_data, output ready);
endinterface

interface canaf_res_if #(
  parameter int CntW = 6
);
  import canaf_pkg::*;

  logic              valid;
  logic              ready;
  logic [StatW-1:0]  status;
  logic              accepted;
  logic [IdW-1:0]    out_id;
  logic [DlcW-1:0]   out_dlc;
  logic [DataW-1:0]  out_data;
  logic [CntW-1:0]   fill_count;
  logic [OvfW-1:0]   overflow_total;

  modport source (output valid, status, accepted, out_id, out_dlc, out_data, fill_count,
                  overflow_total, input ready);
  modport sink   (input valid, status, accepted, out_id, out_dlc, out_data, fill_count,
                  overflow_total, output ready);
endinterface

[src/canaf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module canaf_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/canaf_filter.sv]
// Four-bank mask and identifier acceptance filter.
module canaf_filter (
  input  canaf_pkg::active_t   active_i,
  input  canaf_pkg::bank_t     banks_i [canaf_pkg::NumBanks],
  input  logic [canaf_pkg::IdW-1:0] id_i,
  output canaf_pkg::filt_res_t res_o
);
  import canaf_pkg::*;

  logic [NumBanks-1:0] bank_hit;

  always_comb begin
    for (int n = 0; n < NumBanks; n++) begin
      bank_hit[n] = active_i[n] &&
                    ((id_i & banks_i[n].mask) == (banks_i[n].ident & banks_i[n].mask));
    end
  end

  assign res_o.any_on = |active_i;
  assign res_o.hit    = |bank_hit;

endmodule

[src/can_acceptance_filter_rx_fifo_unit.sv]
// Top level of the CAN receive path: acceptance filter, receive FIFO and drop counter.
//
//   channel  direction  handshake       carries
//   req      in         valid/ready     mode, frame_id, frame_dlc, frame_data
//   res      out        valid/ready     status, accepted, frame fields, fill and drop counts
//   cfg      in         cfg_we_i        filter enable bits and four filter banks
//
// One request is taken per cycle while req.ready is high; its result passes through the
// request stage, where a pop waits for the registered read of the frame RAMs, and then goes
// to the output register. Reset clears the pointers, the fill count, the drop counter and the
// filter registers; the frame RAMs are not cleared, as only written entries are ever read.
// A stalled result register holds the request stage, and req.ready falls only while both
// stages are full and res.ready is low.
module can_acceptance_filter_rx_fifo_unit #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [canaf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [canaf_pkg::BankW-1:0]    cfg_wdata_i,
  canaf_req_if.sink                      req,
  canaf_res_if.source                    res
);
  import canaf_pkg::*;

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  // Filter configuration
  active_t active_q;
  bank_t   bank_q [NumBanks];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int n = 0; n < NumBanks; n++) begin
        bank_q[n] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ACTIVE: active_q  <= cfg_wdata_i[NumBanks-1:0];
        CFG_BANK0:  bank_q[0] <= cfg_wdata_i;
        CFG_BANK1:  bank_q[1] <= cfg_wdata_i;
        CFG_BANK2:  bank_q[2] <= cfg_wdata_i;
        CFG_BANK3:  bank_q[3] <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  filt_res_t filt;

  canaf_filter u_filter (
    .active_i (active_q),
    .banks_i  (bank_q),
    .id_i     (req.frame_id),
    .res_o    (filt)
  );

  // FIFO state
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [OvfW-1:0] ovf_q, ovf_d;

  // Request stage, waiting for the RAM read
  logic            s1_valid_q, s1_valid_d;
  status_e         s1_status_q, s1_status_d;
  logic            s1_acc_q, s1_acc_d;
  logic            s1_pop_q, s1_pop_d;
  logic [CntW-1:0] s1_fill_q;
  logic [OvfW-1:0] s1_ovf_q;

  // Output register
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q;
  logic             out_acc_q;
  logic [IdW-1:0]   out_id_q;
  logic [DlcW-1:0]  out_dlc_q;
  logic [DataW-1:0] out_data_q;
  logic [CntW-1:0]  out_fill_q;
  logic [OvfW-1:0]  out_ovf_q;

  logic            accept, out_free, s1_adv;
  logic            ram_we, ram_re;
  logic            dlc_bad, is_full;
  logic [HdrW-1:0] hdr_rdata;
  logic [DataW-1:0] pay_rdata;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free  = !out_valid_q || res.ready;
  assign s1_adv    = s1_valid_q && out_free;
  assign req.ready = !s1_valid_q || out_free;
  assign accept    = req.valid && req.ready;
  assign dlc_bad   = req.frame_dlc > DlcW'(MaxDlc);
  assign is_full   = cnt_q == CntW'(FIFO_DEPTH);

  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    s1_status_d = ST_OK;
    s1_acc_d    = 1'b0;
    s1_pop_d    = 1'b0;
    if (accept) begin
      unique case (mode_e'(req.mode))
        MODE_PUSH: begin
          if (dlc_bad) begin
            s1_status_d = ST_ERR;
          end else if (filt.hit || !filt.any_on) begin
            s1_acc_d = 1'b1;
            if (is_full) begin
              s1_status_d = ST_ERR;
              if (ovf_q != '1) begin
                ovf_d = ovf_q + 1'b1;
              end
            end else begin
              ram_we   = 1'b1;
              wr_ptr_d = ptr_next(wr_ptr_q);
              cnt_d    = cnt_q + 1'b1;
            end
          end
        end
        MODE_POP: begin
          if (cnt_q == '0) begin
            s1_status_d = ST_EMPTY;
          end else begin
            ram_re   = 1'b1;
            s1_pop_d = 1'b1;
            rd_ptr_d = ptr_next(rd_ptr_q);
            cnt_d    = cnt_q - 1'b1;
          end
        end
        MODE_FLUSH: begin
          wr_ptr_d = '0;
          rd_ptr_d = '0;
          cnt_d    = '0;
        end
        default: begin
          s1_status_d = ST_ERR;
        end
      endcase
    end
  end

  assign s1_valid_d  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (res.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      ovf_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= s1_status_d;
      s1_acc_q    <= s1_acc_d;
      s1_pop_q    <= s1_pop_d;
      s1_fill_q   <= cnt_d;
      s1_ovf_q    <= ovf_d;
    end
    if (s1_adv) begin
      out_status_q <= s1_status_q;
      out_acc_q    <= s1_acc_q;
      out_id_q     <= s1_pop_q ? hdr_rdata[IdW-1:0] : '0;
      out_dlc_q    <= s1_pop_q ? hdr_rdata[HdrW-1:IdW] : '0;
      out_data_q   <= s1_pop_q ? pay_rdata : '0;
      out_fill_q   <= s1_fill_q;
      out_ovf_q    <= s1_ovf_q;
    end
  end

  canaf_ram #(
    .Width (HdrW),
    .Depth (FIFO_DEPTH)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i ({req.frame_dlc, req.frame_id}),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (hdr_rdata)
  );

  canaf_ram #(
    .Width (DataW),
    .Depth (FIFO_DEPTH)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (req.frame_data),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (pay_rdata)
  );

  assign res.valid          = out_valid_q;
  assign res.status         = out_status_q;
  assign res.accepted       = out_acc_q;
  assign res.out_id         = out_id_q;
  assign res.out_dlc        = out_dlc_q;
  assign res.out_data       = out_data_q;
  assign res.fill_count     = out_fill_q;
  assign res.overflow_total = out_ovf_q;

endmodule

[src/canaf_checker.sv]
// Port-level checks of the CAN receive FIFO, bound to the top level.
module canaf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  canaf_req_if.sink   req,
  canaf_res_if.source res
);
  import canaf_pkg::*;

  logic res_take;
  assign res_take = res.valid && res.ready;

  // A stalled result keeps its request's values.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.status) &&
                                   $stable(res.fill_count) && $stable(res.out_data)))
    else $error("result changed while stalled");

  // An empty pop carries no frame and reports an empty FIFO.
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res.status == ST_EMPTY) |->
      (res.fill_count == '0 && res.out_id == '0 && res.out_dlc == '0 &&
       res.out_data == '0 && !res.accepted))
    else $error("empty pop carries frame data");

  // Only a successful pop shows a length code, and it is a legal one.
  a_pop_dlc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res.out_dlc != '0) |->
      (res.status == ST_OK && !res.accepted && res.out_dlc <= DlcW'(MaxDlc)))
    else $error("frame length code on a result that is not a pop");

  // The drop counter never goes down between results taken back to back.
  a_ovf_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_take && $past(res_take)) |-> (res.overflow_total >= $past(res.overflow_total)))
    else $error("drop counter decreased");

endmodule

bind can_acceptance_filter_rx_fifo_unit canaf_checker u_canaf_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req    (req),
  .res    (res)
);
